>>> rtl/vsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsw_pkg
// shared types and constants for the varint sink writer
// ----------------------------------------------------------------------------
package vsw_pkg;

  localparam int unsigned PosW      = 17;
  localparam int unsigned GroupBits = 7;
  localparam logic [PosW-1:0] BufSizeReset = 17'd65536;
  localparam logic [7:0] GroupMask = 8'h7F;
  localparam logic [7:0] ContBit   = 8'h80;

  typedef enum logic [2:0] {
    REQ_RAW     = 3'd0,
    REQ_BOOL    = 3'd1,
    REQ_INT32   = 3'd2,
    REQ_INT64   = 3'd3,
    REQ_UINT32  = 3'd4,
    REQ_RESTART = 3'd5
  } vsw_req_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } vsw_state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] value;
  } vsw_in_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [PosW-1:0] byte_address;
    logic            dropped;
    logic            last_byte;
  } vsw_out_t;

  // encoder control: load a new operand (raw or varint) or step to the next group
  typedef struct packed {
    logic load;
    logic step;
    logic raw;
  } vsw_enc_ctrl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } vsw_enc_stat_t;

  // position counter control
  typedef struct packed {
    logic clear;
    logic step;
  } vsw_pos_ctrl_t;

  typedef struct packed {
    logic [PosW-1:0] addr;
    logic            full;
  } vsw_pos_stat_t;

endpackage

>>> rtl/varint_sink_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_sink_writer_core
// base-128 varint serializer into a bounded byte buffer, one byte per cycle
// ----------------------------------------------------------------------------
//
//  channel   signals                               payload
//  --------  ------------------------------------  ---------------------------
//  in        in_valid_i  / in_ready_o  / in_i       req_type, value
//  out       out_valid_o / out_ready_i / out_o      byte, address, flags
//  cfg       cfg_valid_i / cfg_ready_o / cfg_data_i buffer_size (17 bits)
//
//  an input transaction is loaded in the accept cycle, then the encoder emits
//  its bytes in turn: 1 byte for raw or bool, 1 to 5 for 32-bit varints,
//  1 to 10 for int64, 10 for a negative int32
//  bytes come from the single shared 7-bit shifter, one group per cycle
//  restart and unknown request types finish in the accept cycle
//  the output register stalls the sequencer while a byte waits on out_ready_i
//  reset clears the write position and sets buffer_size to 65536
//
module varint_sink_writer_core import vsw_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vsw_in_t         in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vsw_out_t        out_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [PosW-1:0] cfg_data_i
);

  // capacity widened to 25 bits so that parameter values below 2**25 compare correctly
  localparam logic [24:0] CapW = 25'(BUFFER_BYTES);

  vsw_state_e      state_q, state_d;
  logic [PosW-1:0] buf_size_q, buf_size_d;
  logic [PosW-1:0] limit;
  logic            out_valid_q, out_valid_d;
  vsw_out_t        out_q, out_d;

  logic            in_fire;
  logic            is_encode;
  logic            slot_free;
  logic            emit;
  logic [63:0]     load_value;

  vsw_enc_ctrl_t   enc_ctrl;
  vsw_enc_stat_t   enc_stat;
  vsw_pos_ctrl_t   pos_ctrl;
  vsw_pos_stat_t   pos_stat;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_comb begin
    buf_size_d = buf_size_q;
    if (cfg_valid_i && cfg_ready_o) begin
      buf_size_d = cfg_data_i;
    end
  end

  // effective limit is the smaller of the register and the physical buffer
  assign limit = ({8'd0, buf_size_q} < CapW) ? buf_size_q : CapW[PosW-1:0];

  // ---------------------------------------------------------------- decode
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    is_encode  = 1'b1;
    load_value = '0;
    case (in_i.req_type)
      REQ_RAW:     load_value = {56'd0, in_i.value[7:0]};
      REQ_BOOL:    load_value = {63'd0, |in_i.value};
      REQ_INT32: begin
        // negative int32 goes out sign-extended as a ten-byte varint
        load_value = {{32{in_i.value[31]}}, in_i.value[31:0]};
      end
      REQ_INT64:   load_value = in_i.value;
      REQ_UINT32:  load_value = {32'd0, in_i.value[31:0]};
      default:     is_encode = 1'b0;  // restart and unknown codes emit nothing
    endcase
  end

  // a new byte may enter the output register when it is empty or draining
  assign slot_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_encode) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && enc_stat.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    emit          = 1'b0;
    enc_ctrl      = '0;
    pos_ctrl      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        enc_ctrl.load  = in_fire && is_encode;
        enc_ctrl.raw   = (in_i.req_type == REQ_RAW) || (in_i.req_type == REQ_BOOL);
        pos_ctrl.clear = in_fire && (in_i.req_type == REQ_RESTART);
      end
      ST_EMIT: begin
        emit          = slot_free;
        enc_ctrl.step = slot_free;
        pos_ctrl.step = slot_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- units
  vsw_enc_unit u_enc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (enc_ctrl),
    .load_value_i (load_value),
    .stat_o       (enc_stat)
  );

  vsw_pos_unit u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pos_ctrl),
    .limit_i (limit),
    .stat_o  (pos_stat)
  );

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d        = 1'b1;
      out_d.data_byte    = enc_stat.data;
      out_d.byte_address = pos_stat.addr;
      out_d.dropped      = pos_stat.full;
      out_d.last_byte    = enc_stat.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      buf_size_q  <= BufSizeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_size_q  <= buf_size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  // restart transaction clears the position
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.req_type == REQ_RESTART) |=> pos_stat.addr == '0 || pos_stat.full)
    else $error("write position not cleared by restart");

  // a byte that is written advances the position by one
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !pos_stat.full |=> u_pos.pos_q == $past(u_pos.pos_q) + 1'b1)
    else $error("write position did not advance");

  // the final byte of a request returns the sequencer to accepting input
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && enc_stat.last |=> in_ready_o)
    else $error("sequencer stuck after last byte");

  // input is never taken while bytes of a request remain
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !enc_stat.last |=> !in_ready_o)
    else $error("input accepted mid-request");
`endif

endmodule

>>> rtl/vsw_enc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsw_enc_unit
// operand register with the shared 7-bit shifter and group-remaining compare
// ----------------------------------------------------------------------------
module vsw_enc_unit import vsw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vsw_enc_ctrl_t ctrl_i,
  input  logic [63:0]   load_value_i,
  output vsw_enc_stat_t stat_o
);

  logic [63:0] val_q, val_d;
  logic        raw_q, raw_d;
  logic        more;

  // more groups follow when anything is left above the low group
  assign more = |val_q[63:GroupBits];

  always_comb begin
    val_d = val_q;
    raw_d = raw_q;
    if (ctrl_i.load) begin
      val_d = load_value_i;
      raw_d = ctrl_i.raw;
    end else if (ctrl_i.step) begin
      val_d = val_q >> GroupBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      raw_q <= 1'b0;
    end else begin
      val_q <= val_d;
      raw_q <= raw_d;
    end
  end

  always_comb begin
    if (raw_q) begin
      stat_o.data = val_q[7:0];
      stat_o.last = 1'b1;
    end else begin
      stat_o.data = (val_q[7:0] & GroupMask) | (more ? ContBit : 8'h00);
      stat_o.last = ~more;
    end
  end

endmodule

>>> rtl/vsw_pos_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsw_pos_unit
// write position counter with the buffer-full compare
// ----------------------------------------------------------------------------
module vsw_pos_unit import vsw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vsw_pos_ctrl_t   ctrl_i,
  input  logic [PosW-1:0] limit_i,
  output vsw_pos_stat_t   stat_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            full;

  assign full = (pos_q >= limit_i);

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.clear) begin
      pos_d = '0;
    end else if (ctrl_i.step && !full) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign stat_o.addr = full ? limit_i : pos_q;
  assign stat_o.full = full;

endmodule
